// ----- design/cnlb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnlb_pkg: shared types and constants for the card number class checker
// Widths of the binary input and the decimal digit row, class codes and the
// record that moves from one conversion cell to the next.
// ----------------------------------------------------------------------------
package cnlb_pkg;

    localparam int BIN_W          = 63;
    localparam int BCD_DIGITS     = 19;
    localparam int BCD_W          = 4 * BCD_DIGITS;
    localparam int CLASS_W        = 3;
    localparam int MAX_DIGITS_DEF = 16;
    localparam int LUHN_HALF      = 8;
    localparam int HALF_SUM_W     = 7;
    localparam int SUM_W          = 8;

    localparam logic [CLASS_W-1:0] CLASS_INVALID = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_16_LEAD4 = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_16_LEAD5 = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_15_LEAD3 = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_13_LEAD4 = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
    } t_cell;

endpackage

// ----- design/cnlb_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnlb_cell: one shift-and-add-3 conversion cell
// Corrects every decimal digit of 5 or more by 3, then shifts the next binary
// bit into the digit row and registers the result for the next cell.
// ----------------------------------------------------------------------------
module cnlb_cell
    import cnlb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cell i_cell,
    output t_cell o_cell
);

    logic             r_valid;
    logic [BCD_W-1:0] r_bcd;
    logic [BIN_W-1:0] r_bin;
    logic [BCD_W-1:0] n_bcd;
    logic [BIN_W-1:0] n_bin;
    logic [BCD_W-1:0] w_adj;

    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (i_cell.bcd[4*k +: 4] >= 4'd5) begin
                w_adj[4*k +: 4] = i_cell.bcd[4*k +: 4] + 4'd3;
            end else begin
                w_adj[4*k +: 4] = i_cell.bcd[4*k +: 4];
            end
        end
        n_bcd = {w_adj[BCD_W-2:0], i_cell.bin[BIN_W-1]};
        n_bin = {i_cell.bin[BIN_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        r_bin <= n_bin;
    end

    assign o_cell.valid = r_valid;
    assign o_cell.bcd   = r_bcd;
    assign o_cell.bin   = r_bin;

endmodule

// ----- design/cnlb_classify.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnlb_classify: length, prefix and Luhn check on the decimal digit row
// Stage one finds the class from length and leading digits and forms two
// half sums of the Luhn terms; stage two adds them and keeps the class only
// when the total is a multiple of ten.
// ----------------------------------------------------------------------------
module cnlb_classify
    import cnlb_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [BCD_W-1:0]   i_bcd,
    output logic               o_valid,
    output logic [CLASS_W-1:0] o_card_class
);

    function automatic logic [3:0] luhn_term(input logic [3:0] d, input logic dbl);
        logic [3:0] t;
        if (!dbl) begin
            t = d;
        end else if (d >= 4'd5) begin
            t = 4'((d << 1) - 4'd9);
        end else begin
            t = 4'(d << 1);
        end
        return t;
    endfunction

    function automatic logic is_mult10(input logic [SUM_W-1:0] s);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k <= 2 * LUHN_HALF * 9 / 10; k++) begin
            if (s == SUM_W'(k * 10)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    logic [3:0] w_d [BCD_DIGITS];
    logic       w_upper_zero;
    logic       w_len16;
    logic       w_len15;
    logic       w_len13;
    logic [CLASS_W-1:0]    n_s1_class;
    logic [HALF_SUM_W-1:0] n_sum_lo;
    logic [HALF_SUM_W-1:0] n_sum_hi;
    logic [SUM_W-1:0]      w_total;

    logic                  r_s1_valid;
    logic [CLASS_W-1:0]    r_s1_class;
    logic [HALF_SUM_W-1:0] r_sum_lo;
    logic [HALF_SUM_W-1:0] r_sum_hi;
    logic                  r_out_valid;
    logic [CLASS_W-1:0]    r_out_class;

    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            w_d[k] = i_bcd[4*k +: 4];
        end
        w_upper_zero = (i_bcd[BCD_W-1:64] == '0);
        w_len16 = w_upper_zero && (w_d[15] != 4'd0);
        w_len15 = w_upper_zero && (w_d[15] == 4'd0) && (w_d[14] != 4'd0);
        w_len13 = w_upper_zero && (i_bcd[63:52] == '0) && (w_d[12] != 4'd0);

        n_s1_class = CLASS_INVALID;
        if (w_len16 && (MAX_DIGITS >= 16)) begin
            if (w_d[15] == 4'd4) begin
                n_s1_class = CLASS_16_LEAD4;
            end else if ((w_d[15] == 4'd5) && (w_d[14] >= 4'd1) && (w_d[14] <= 4'd5)) begin
                n_s1_class = CLASS_16_LEAD5;
            end
        end else if (w_len15 && (MAX_DIGITS >= 15)) begin
            if ((w_d[14] == 4'd3) && ((w_d[13] == 4'd4) || (w_d[13] == 4'd7))) begin
                n_s1_class = CLASS_15_LEAD3;
            end
        end else if (w_len13) begin
            if (w_d[12] == 4'd4) begin
                n_s1_class = CLASS_13_LEAD4;
            end
        end

        n_sum_lo = '0;
        n_sum_hi = '0;
        for (int k = 0; k < LUHN_HALF; k++) begin
            n_sum_lo = n_sum_lo + HALF_SUM_W'(luhn_term(w_d[k], k[0]));
            n_sum_hi = n_sum_hi + HALF_SUM_W'(luhn_term(w_d[k+LUHN_HALF], k[0]));
        end

        w_total = SUM_W'(r_sum_lo) + SUM_W'(r_sum_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_class <= n_s1_class;
        r_sum_lo   <= n_sum_lo;
        r_sum_hi   <= n_sum_hi;
        r_out_class <= is_mult10(w_total) ? r_s1_class : CLASS_INVALID;
    end

    assign o_valid      = r_out_valid;
    assign o_card_class = r_out_class;

    a_class_from_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_class == CLASS_INVALID || r_out_class == $past(r_s1_class)))
        else $error("class differs from stage one class");

    a_stage_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_s1_valid))
        else $error("result without stage one item");

endmodule

// ----- design/card_number_luhn_brand_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_number_luhn_brand_check: card number class and Luhn mod-10 check
// Converts the binary number to decimal digits in a row of shift-and-add-3
// cells, then checks length, leading digits and the Luhn sum.
//
// channel   signals                     direction  transfer when
// input     start, busy, i_card_number  in         start && !busy
// result    o_valid, o_card_class       out        o_valid (one cycle)
//
// One item per cycle; busy stays low, so a new item may enter every cycle.
// The path has 63 conversion cells, one bit each, plus two check
// stages. Reset (synchronous, active low) clears the valid bits of every
// stage and drops items in flight. The receiver takes each result in the
// cycle it appears.
// ----------------------------------------------------------------------------
module card_number_luhn_brand_check
    import cnlb_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [BIN_W-1:0]   i_card_number,
    output logic               o_valid,
    output logic [CLASS_W-1:0] o_card_class
);

    localparam int LATENCY = BIN_W + 2;

    t_cell w_chain [BIN_W+1];

    assign busy = 1'b0;

    assign w_chain[0].valid = start && !busy;
    assign w_chain[0].bcd   = '0;
    assign w_chain[0].bin   = i_card_number;

    for (genvar g = 0; g < BIN_W; g++) begin : g_cell
        cnlb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    cnlb_classify #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_chain[BIN_W].valid),
        .i_bcd        (w_chain[BIN_W].bcd),
        .o_valid      (o_valid),
        .o_card_class (o_card_class)
    );

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without matching input transfer");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_card_class <= CLASS_13_LEAD4))
        else $error("class code out of range");

endmodule
